[rtl/bfm_pkg.sv]
// bfm_pkg: shared types and constants of the buffer frame manager
// depends on nothing; used by every module under rtl
package bfm_pkg;

	localparam int NUM_FRAMES_DEF = 16;
	localparam int PIN_BITS_DEF   = 8;
	localparam int PAGE_W         = 31;
	localparam int MODE_W         = 3;
	localparam int STATUS_W       = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_FETCH  = 3'd0,
		MODE_UNPIN  = 3'd1,
		MODE_FLUSH  = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_NEW    = 3'd4
	} mode_t;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_RES  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REFUSE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PIN_OVF  = 3'd4;

	typedef enum logic [1:0] {
		CT_IDLE,
		CT_SEARCH,
		CT_EXEC,
		CT_OUT
	} ctrl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic search;
		logic exec;
	} cmd_t;

endpackage

[rtl/buffer_frame_manager_lru.sv]
// buffer_frame_manager_lru: buffer pool frame manager with lru replacement
// one request at a time: a request is taken only in idle, and another only after the
// result of the last one has been transferred (idle, search, execute, result hold in
// bfm_ctrl)
// reset: all frames free in order 0 up, lru list empty, no pins, nothing dirty
// depends on bfm_pkg, bfm_ctrl, bfm_dp
module buffer_frame_manager_lru #(
	parameter int NUM_FRAMES = bfm_pkg::NUM_FRAMES_DEF,
	parameter int PIN_BITS   = bfm_pkg::PIN_BITS_DEF,
	localparam int FW        = $clog2(NUM_FRAMES),
	localparam int OUT_W     = ((FW + 35 + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request side
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [31:0]                      s_axis_tdata,  // page_id[30:0], mark_dirty
	input  logic [bfm_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
	// result side
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// frame, write_back, victim_page, read_page, clear_frame, release_page, zero pad
	output logic [OUT_W-1:0]                 m_axis_tdata,
	output logic [bfm_pkg::STATUS_W-1:0]     m_axis_tuser   // status
);

	localparam int CW = $clog2(NUM_FRAMES + 1);

	bfm_pkg::cmd_t                cmd;
	logic [bfm_pkg::STATUS_W-1:0] res_status;
	logic [FW-1:0]                res_frame;
	logic                         res_wb, res_read, res_clear, res_release;
	logic [bfm_pkg::PAGE_W-1:0]   res_victim;
	logic [CW-1:0]                free_cnt, lru_cnt;

	// sequencer: idle, search tags, execute, hold result until transfer
	bfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// frame table, free ring, lru list and result registers
	bfm_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.PIN_BITS   (PIN_BITS),
		.FW         (FW),
		.CW         (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_mode    (s_axis_tuser),
		.req_page    (s_axis_tdata[30:0]),
		.req_mark    (s_axis_tdata[31]),
		.res_status  (res_status),
		.res_frame   (res_frame),
		.res_wb      (res_wb),
		.res_victim  (res_victim),
		.res_read    (res_read),
		.res_clear   (res_clear),
		.res_release (res_release),
		.free_cnt    (free_cnt),
		.lru_cnt     (lru_cnt)
	);

	// result packing, lowest field first
	assign m_axis_tdata = OUT_W'({res_release, res_clear, res_read, res_victim, res_wb,
		res_frame});
	assign m_axis_tuser = res_status;

	// one request at a time: never take a request while a result waits
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("request taken while result pending");

	// the free ring and the lru list together never hold more entries than there are frames
	a_frame_budget: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, free_cnt} + {1'b0, lru_cnt}) <= (CW+1)'(NUM_FRAMES))
		else $error("free and lru counts exceed pool size");

	// result valid is raised after the search and execute states that follow each request transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> ##3 m_axis_tvalid)
		else $error("result late");

endmodule

[rtl/bfm_ctrl.sv]
// bfm_ctrl: request sequencer of the buffer frame manager
// depends on bfm_pkg; drives the commands of bfm_dp
module bfm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bfm_pkg::cmd_t cmd
);

	bfm_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfm_pkg::CT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			bfm_pkg::CT_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bfm_pkg::CT_SEARCH;
				end
			end
			bfm_pkg::CT_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = bfm_pkg::CT_EXEC;
			end
			bfm_pkg::CT_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = bfm_pkg::CT_OUT;
			end
			bfm_pkg::CT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = bfm_pkg::CT_IDLE;
				end
			end
			default: state_d = bfm_pkg::CT_IDLE;
		endcase
	end

endmodule

[rtl/bfm_dp.sv]
// bfm_dp: frame table, free ring, lru list and result registers
// depends on bfm_pkg; sequenced by bfm_ctrl
module bfm_dp #(
	parameter int NUM_FRAMES = bfm_pkg::NUM_FRAMES_DEF,
	parameter int PIN_BITS   = bfm_pkg::PIN_BITS_DEF,
	parameter int FW         = $clog2(NUM_FRAMES),
	parameter int CW         = $clog2(NUM_FRAMES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfm_pkg::cmd_t                 cmd,
	input  logic [bfm_pkg::MODE_W-1:0]    req_mode,
	input  logic [bfm_pkg::PAGE_W-1:0]    req_page,
	input  logic                          req_mark,
	output logic [bfm_pkg::STATUS_W-1:0]  res_status,
	output logic [FW-1:0]                 res_frame,
	output logic                          res_wb,
	output logic [bfm_pkg::PAGE_W-1:0]    res_victim,
	output logic                          res_read,
	output logic                          res_clear,
	output logic                          res_release,
	output logic [CW-1:0]                 free_cnt,
	output logic [CW-1:0]                 lru_cnt
);

	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	// frame table
	logic [bfm_pkg::PAGE_W-1:0] tag_q   [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]      valid_q;
	logic [PIN_BITS-1:0]        pins_q  [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]      dirty_q;
	// free ring and lru list
	logic [FW-1:0]              ring_q  [NUM_FRAMES];
	logic [FW-1:0]              head_q;
	logic [CW-1:0]              fcnt_q;
	logic [FW-1:0]              lru_q   [NUM_FRAMES];
	logic [CW-1:0]              lcnt_q;
	// request
	logic [bfm_pkg::MODE_W-1:0] mode_q;
	logic [bfm_pkg::PAGE_W-1:0] page_q;
	logic                       mark_q;
	// search stage
	logic                       hit_s2, take_free_s2, take_ok_s2;
	logic [FW-1:0]              hidx_s2, take_s2;

	logic                       hit_c;
	logic [FW-1:0]              hidx_c;

	always_comb begin
		hit_c  = 1'b0;
		hidx_c = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == page_q) begin
				hit_c  = 1'b1;
				hidx_c = FW'(i);
			end
		end
	end

	// execute stage
	logic [FW-1:0]              t;
	logic [PIN_BITS-1:0]        cur_pins;
	logic                       cur_dirty, cur_valid;
	logic [bfm_pkg::STATUS_W-1:0] st;
	logic [FW-1:0]              fr;
	logic                       wb, rd, clr, rel;
	logic [bfm_pkg::PAGE_W-1:0] victim;
	logic                       alloc, inc, dec, setd, clrd, dofree, pop, rm, add;
	logic [NUM_FRAMES-1:0]      lm, rmv;
	logic [CW:0]                push_sum;
	logic [FW-1:0]              push_idx;

	assign t         = hit_s2 ? hidx_s2 : take_s2;
	assign cur_pins  = pins_q[t];
	assign cur_dirty = dirty_q[t];
	assign cur_valid = valid_q[t];

	always_comb begin
		st = bfm_pkg::ST_OK;
		fr = '0;
		wb = 1'b0; rd = 1'b0; clr = 1'b0; rel = 1'b0;
		victim = '0;
		alloc = 1'b0; inc = 1'b0; dec = 1'b0; setd = 1'b0; clrd = 1'b0;
		dofree = 1'b0; pop = 1'b0; rm = 1'b0; add = 1'b0;
		unique case (mode_q)
			bfm_pkg::MODE_FETCH, bfm_pkg::MODE_NEW: begin
				if (hit_s2 && mode_q == bfm_pkg::MODE_FETCH) begin
					fr = hidx_s2;
					if (cur_pins == PIN_MAX) begin
						st = bfm_pkg::ST_PIN_OVF;
					end else begin
						inc = 1'b1;
						rm  = (cur_pins == '0);
					end
				end else if (hit_s2) begin
					st = bfm_pkg::ST_REFUSE;
					fr = hidx_s2;
				end else if (!take_ok_s2) begin
					st = bfm_pkg::ST_NO_FRAME;
				end else begin
					fr    = take_s2;
					alloc = 1'b1;
					pop   = take_free_s2;
					rm    = !take_free_s2;
					if (cur_valid && cur_dirty) begin
						wb     = 1'b1;
						victim = tag_q[t];
					end
					rd  = (mode_q == bfm_pkg::MODE_FETCH);
					clr = (mode_q == bfm_pkg::MODE_NEW);
				end
			end
			bfm_pkg::MODE_UNPIN: begin
				if (!hit_s2) begin
					st = bfm_pkg::ST_NOT_RES;
				end else begin
					fr = hidx_s2;
					if (cur_pins == '0) begin
						st = bfm_pkg::ST_REFUSE;
					end else begin
						dec  = 1'b1;
						add  = (cur_pins == PIN_BITS'(1));
						setd = mark_q;
					end
				end
			end
			bfm_pkg::MODE_FLUSH: begin
				if (!hit_s2) begin
					st = bfm_pkg::ST_NOT_RES;
				end else begin
					fr = hidx_s2;
					if (cur_dirty) begin
						wb     = 1'b1;
						victim = page_q;
						clrd   = 1'b1;
					end
				end
			end
			bfm_pkg::MODE_DELETE: begin
				rel = 1'b1;
				if (hit_s2) begin
					fr = hidx_s2;
					if (cur_pins != '0) begin
						st  = bfm_pkg::ST_REFUSE;
						rel = 1'b0;
					end else begin
						dofree = 1'b1;
						rm     = 1'b1;
						clr    = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// lru removal: entries at and after the match move up one place
	always_comb begin
		for (int j = 0; j < NUM_FRAMES; j++) begin
			lm[j] = (lru_q[j] == t) && (CW'(j) < lcnt_q);
		end
		rmv[0] = lm[0];
		for (int j = 1; j < NUM_FRAMES; j++) begin
			rmv[j] = rmv[j-1] | lm[j];
		end
	end

	always_comb begin
		push_sum = {1'b0, CW'(head_q)} + {1'b0, fcnt_q};
		if (push_sum >= (CW+1)'(NUM_FRAMES)) begin
			push_sum = push_sum - (CW+1)'(NUM_FRAMES);
		end
		push_idx = push_sum[FW-1:0];
	end

	// valid, dirty and pin state, free ring and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			head_q  <= '0;
			fcnt_q  <= CW'(NUM_FRAMES);
			lcnt_q  <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				pins_q[i] <= '0;
				ring_q[i] <= FW'(i);
			end
		end else if (cmd.exec) begin
			if (alloc) begin
				valid_q[t] <= 1'b1;
				dirty_q[t] <= 1'b0;
				pins_q[t]  <= PIN_BITS'(1);
			end
			if (inc) pins_q[t] <= cur_pins + PIN_BITS'(1);
			if (dec) pins_q[t] <= cur_pins - PIN_BITS'(1);
			if (setd) dirty_q[t] <= 1'b1;
			if (clrd) dirty_q[t] <= 1'b0;
			if (dofree) begin
				valid_q[t] <= 1'b0;
				dirty_q[t] <= 1'b0;
				pins_q[t]  <= '0;
				ring_q[push_idx] <= t;
				fcnt_q <= fcnt_q + CW'(1);
			end
			if (pop) begin
				head_q <= (head_q == FW'(NUM_FRAMES - 1)) ? '0 : head_q + FW'(1);
				fcnt_q <= fcnt_q - CW'(1);
			end
			if (rm && (|lm)) lcnt_q <= lcnt_q - CW'(1);
			if (add) lcnt_q <= lcnt_q + CW'(1);
		end
	end

	// payload: request, search results, tags, lru entries and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req_mode;
			page_q <= req_page;
			mark_q <= req_mark;
		end
		if (cmd.search) begin
			hit_s2       <= hit_c;
			hidx_s2      <= hidx_c;
			take_free_s2 <= (fcnt_q != '0);
			take_ok_s2   <= (fcnt_q != '0) || (lcnt_q != '0);
			take_s2      <= (fcnt_q != '0) ? ring_q[head_q] : lru_q[0];
		end
		if (cmd.exec) begin
			if (alloc) tag_q[t] <= page_q;
			if (rm) begin
				for (int j = 0; j < NUM_FRAMES; j++) begin
					if (rmv[j] && j + 1 < NUM_FRAMES) lru_q[j] <= lru_q[(j + 1) % NUM_FRAMES];
				end
			end
			if (add) lru_q[lcnt_q[FW-1:0]] <= t;
			res_status  <= st;
			res_frame   <= fr;
			res_wb      <= wb;
			res_victim  <= victim;
			res_read    <= rd;
			res_clear   <= clr;
			res_release <= rel;
		end
	end

	assign free_cnt = fcnt_q;
	assign lru_cnt  = lcnt_q;

endmodule

[bench/tb_buffer_frame_manager_lru.sv]
// tb_buffer_frame_manager_lru: self-checking bench for the lru buffer frame manager
// drives page requests on the request stream; checks each result against its typed row, else a
// frame-table predictor kept in the bench; depends on bfm_pkg and buffer_frame_manager_lru
module tb_buffer_frame_manager_lru;

	localparam int NFR   = 16;
	localparam int OUT_W = 40;
	localparam logic [30:0] PMAX = 31'h7FFF_FFFF;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;    // page_id[30:0], mark_dirty
	logic [bfm_pkg::MODE_W-1:0] s_axis_tuser;  // mode
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;  // frame, write_back, victim_page, read_page, clear_frame, release_page
	logic [bfm_pkg::STATUS_W-1:0] m_axis_tuser;  // status

	buffer_frame_manager_lru DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame;
		logic        wb;
		logic [30:0] victim;
		logic        rd;
		logic        clr;
		logic        rel;
	} result_t;

	typedef struct {
		logic [2:0]  mode;
		logic [30:0] page;
		logic        mark;
		bit          typed;   // expected result written in the row
		result_t     want;
	} row_t;

	// predictor copy of the frame table
	logic [30:0] tag_m [NFR];
	logic        valid_m [NFR];
	logic [7:0]  pins_m [NFR];
	logic        dirty_m [NFR];
	logic [3:0]  ring_m [NFR];
	logic [3:0]  head_m;
	int          free_n;
	int          lru_q [$];

	result_t     pending_q [$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_seen = 0;
	bit          quiet = 0;
	bit          hold_req = 0;
	logic [30:0] page_pool [20];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_q.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic result_t zero_res();
		result_t r;
		r.status = bfm_pkg::ST_OK; r.frame = 0; r.wb = 0; r.victim = 0;
		r.rd = 0; r.clr = 0; r.rel = 0;
		return r;
	endfunction

	task automatic clear_table();
		for (int i = 0; i < NFR; i++) begin
			valid_m[i] = 0; pins_m[i] = 0; dirty_m[i] = 0; tag_m[i] = 0;
			ring_m[i] = i[3:0];
		end
		head_m = 0;
		free_n = NFR;
		lru_q.delete();
	endtask

	task automatic lru_drop(input int f);
		for (int i = 0; i < lru_q.size(); i++)
			if (lru_q[i] == f) begin
				lru_q.delete(i);
				return;
			end
	endtask

	// works out one request's result and updates the predictor's table
	task automatic frame_table_step(input logic [2:0] mode, input logic [30:0] page,
			input logic mark, output result_t r);
		int f;
		r = zero_res();
		f = -1;
		for (int i = NFR - 1; i >= 0; i--)
			if (valid_m[i] && tag_m[i] == page) f = i;
		case (mode)
			bfm_pkg::MODE_FETCH, bfm_pkg::MODE_NEW: begin
				if (f >= 0 && mode == bfm_pkg::MODE_FETCH) begin
					r.frame = f[3:0];
					if (pins_m[f] == 8'hFF) r.status = bfm_pkg::ST_PIN_OVF;
					else begin
						if (pins_m[f] == 0) lru_drop(f);
						pins_m[f]++;
					end
				end else if (f >= 0) begin
					r.status = bfm_pkg::ST_REFUSE;
					r.frame = f[3:0];
				end else begin
					if (free_n > 0) begin
						f = ring_m[head_m];
						head_m++;
						free_n--;
					end else if (lru_q.size() > 0) begin
						f = lru_q[0];
						lru_q.delete(0);
					end
					if (f < 0) r.status = bfm_pkg::ST_NO_FRAME;
					else begin
						r.frame = f[3:0];
						if (valid_m[f] && dirty_m[f]) begin
							r.wb = 1;
							r.victim = tag_m[f];
						end
						tag_m[f] = page; valid_m[f] = 1; dirty_m[f] = 0; pins_m[f] = 1;
						if (mode == bfm_pkg::MODE_FETCH) r.rd = 1;
						else r.clr = 1;
					end
				end
			end
			bfm_pkg::MODE_UNPIN: begin
				if (f < 0) r.status = bfm_pkg::ST_NOT_RES;
				else begin
					r.frame = f[3:0];
					if (pins_m[f] == 0) r.status = bfm_pkg::ST_REFUSE;
					else begin
						pins_m[f]--;
						if (pins_m[f] == 0 && lru_q.size() < NFR) lru_q.insert(lru_q.size(), f);
						if (mark) dirty_m[f] = 1;
					end
				end
			end
			bfm_pkg::MODE_FLUSH: begin
				if (f < 0) r.status = bfm_pkg::ST_NOT_RES;
				else begin
					r.frame = f[3:0];
					if (dirty_m[f]) begin
						r.wb = 1; r.victim = page; dirty_m[f] = 0;
					end
				end
			end
			bfm_pkg::MODE_DELETE: begin
				r.rel = 1;
				if (f >= 0) begin
					r.frame = f[3:0];
					if (pins_m[f] != 0) begin
						r.status = bfm_pkg::ST_REFUSE;
						r.rel = 0;
					end else begin
						valid_m[f] = 0; tag_m[f] = 0; dirty_m[f] = 0; pins_m[f] = 0;
						lru_drop(f);
						if (free_n < NFR) begin
							ring_m[head_m + free_n[3:0]] = f[3:0];
							free_n++;
						end
						r.clr = 1;
					end
				end
			end
			default: ;
		endcase
	endtask

	// one request transfer; valid stays high into the next request unless a gap is taken
	task automatic send_request(input logic [2:0] mode, input logic [30:0] page,
			input logic mark, input bit typed, input result_t want);
		result_t r;
		if (!quiet && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {mark, page};
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		frame_table_step(mode, page, mark, r);
		if (typed && r != want)
			$display("note: typed row for mode %0d page %h differs from predictor", mode, page);
		pending_q.insert(pending_q.size(), typed ? want : r);
		n_sent++;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on result %0d: %s got %h want %h", n_seen, what, got, want);
		errors++;
	endtask

	// result side: random stalls, quiet stretches, and one long hold-off
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_left <= 300;
			hold_done <= 1'b1;
		end else if (quiet) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 9);
		end
	end

	// compare each result transfer with the oldest pending one
	always @(posedge clk) begin
		result_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = pending_q[0];
				pending_q.delete(0);
				if (m_axis_tuser !== w.status) report_mismatch("status", m_axis_tuser, w.status);
				if (m_axis_tdata[3:0] !== w.frame) report_mismatch("frame", m_axis_tdata[3:0], w.frame);
				if (m_axis_tdata[4] !== w.wb) report_mismatch("write_back", m_axis_tdata[4], w.wb);
				if (m_axis_tdata[35:5] !== w.victim)
					report_mismatch("victim_page", m_axis_tdata[35:5], w.victim);
				if (m_axis_tdata[36] !== w.rd) report_mismatch("read_page", m_axis_tdata[36], w.rd);
				if (m_axis_tdata[37] !== w.clr) report_mismatch("clear_frame", m_axis_tdata[37], w.clr);
				if (m_axis_tdata[38] !== w.rel) report_mismatch("release_page", m_axis_tdata[38], w.rel);
			end
			n_seen++;
		end
	end

	function automatic row_t mk(input logic [2:0] mode, input logic [30:0] page,
			input logic mark, input bit typed, input logic [2:0] st, input logic [3:0] fr,
			input logic rd, input logic clr, input logic rel);
		row_t t;
		t.mode = mode; t.page = page; t.mark = mark; t.typed = typed;
		t.want = zero_res();
		t.want.status = st; t.want.frame = fr;
		t.want.rd = rd; t.want.clr = clr; t.want.rel = rel;
		return t;
	endfunction

	initial begin
		row_t rows [$];
		logic [2:0] m;
		logic [30:0] pg;
		int k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		clear_table();
		page_pool[0] = 0;
		page_pool[1] = PMAX;
		for (int i = 2; i < 20; i++) page_pool[i] = 31'($urandom() & PMAX);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: absent pages, unused modes, extremes of page id, refusals
		rows.insert(rows.size(), mk(bfm_pkg::MODE_UNPIN, 5, 0, 1, bfm_pkg::ST_NOT_RES, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_FLUSH, 5, 0, 1, bfm_pkg::ST_NOT_RES, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_DELETE, 9, 0, 1, bfm_pkg::ST_OK, 0, 0, 0, 1));
		rows.insert(rows.size(), mk(3'd5, PMAX, 1, 1, bfm_pkg::ST_OK, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(3'd7, 0, 1, 1, bfm_pkg::ST_OK, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_FETCH, 0, 0, 1, bfm_pkg::ST_OK, 0, 1, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_FETCH, PMAX, 0, 1, bfm_pkg::ST_OK, 1, 1, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_NEW, 0, 0, 1, bfm_pkg::ST_REFUSE, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_NEW, 100, 0, 1, bfm_pkg::ST_OK, 2, 0, 1, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_UNPIN, 0, 1, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_UNPIN, 0, 0, 1, bfm_pkg::ST_REFUSE, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_FLUSH, 0, 0, 1, bfm_pkg::ST_OK, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_DELETE, PMAX, 0, 1, bfm_pkg::ST_REFUSE, 1, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_UNPIN, PMAX, 1, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_DELETE, PMAX, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_FETCH, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(3'd6, 123, 0, 1, bfm_pkg::ST_OK, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_UNPIN, 0, 1, 0, 0, 0, 0, 0, 0));
		rows.insert(rows.size(), mk(bfm_pkg::MODE_DELETE, 100, 0, 0, 0, 0, 0, 0, 0));
		foreach (rows[i]) send_request(rows[i].mode, rows[i].page, rows[i].mark,
			rows[i].typed, rows[i].want);

		// no frame: pin every frame, then miss
		for (int i = 0; i < 18; i++)
			send_request(bfm_pkg::MODE_FETCH, 31'(31'h4000_0000 + i), 0, 0, zero_res());
		send_request(bfm_pkg::MODE_NEW, 31'h2AAA_AAAA, 0, 0, zero_res());
		// pin overflow on one frame
		quiet = 1;
		for (int i = 0; i < 256; i++)
			send_request(bfm_pkg::MODE_FETCH, 31'h4000_0003, 0, 0, zero_res());
		quiet = 0;
		// unpin each fetched page once so the random part starts from a mostly unpinned pool
		for (int i = 0; i < 18; i++)
			send_request(bfm_pkg::MODE_UNPIN, 31'(31'h4000_0000 + i), i[0], 0, zero_res());

		for (int n = 0; n < 600; n++) begin
			if (n == 200) hold_req = 1;
			quiet = (n >= 400 && n < 500);
			k = $urandom_range(99);
			if (k < 35) m = bfm_pkg::MODE_FETCH;
			else if (k < 68) m = bfm_pkg::MODE_UNPIN;
			else if (k < 78) m = bfm_pkg::MODE_FLUSH;
			else if (k < 87) m = bfm_pkg::MODE_DELETE;
			else if (k < 96) m = bfm_pkg::MODE_NEW;
			else m = 3'($urandom_range(7, 5));
			pg = ($urandom_range(9) == 0) ? 31'($urandom() & PMAX) : page_pool[$urandom_range(19)];
			send_request(m, pg, 1'($urandom_range(1)), 0, zero_res());
		end
		s_axis_tvalid <= 1'b0;

		while (pending_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d requests over all modes, incl. pin overflow, no-frame, dirty evictions", n_sent);
		$display("checked %0d results with a long result stall midway", n_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[buffer_frame_manager_lru.f]
rtl/bfm_pkg.sv
rtl/bfm_ctrl.sv
rtl/bfm_dp.sv
rtl/buffer_frame_manager_lru.sv
bench/tb_buffer_frame_manager_lru.sv
